// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ufdf_pkg.sv -----
package ufdf_pkg;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_HELD     = 2'd1,
    EV_COMPLETE = 2'd2,
    EV_DROP     = 2'd3
  } event_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [11:0] offset;
    logic [14:0] match_mask;
    logic [12:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic       is_tick;
    logic       is_sync1;
    logic       is_sync2;
    logic [7:0] rx_byte;
  } cls_item_t;

  typedef struct packed {
    logic [14:0]  handle_enable;
    logic [119:0] app_id;
    logic [119:0] msg_min;
    logic [119:0] msg_max;
    logic [11:0]  max_payload;
  } cfg_t;

  localparam int unsigned MASK_W = 15;

  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam logic [12:0] HEADER_BYTES = 13'd8;
  localparam logic [12:0] CRC_BYTES    = 13'd2;

  localparam logic [12:0] POS_SYNC2  = 13'd1;
  localparam logic [12:0] POS_APP_ID = 13'd2;
  localparam logic [12:0] POS_MSG_ID = 13'd3;
  localparam logic [12:0] POS_LEN_HI = 13'd5;
  localparam logic [12:0] POS_LEN_LO = 13'd7;

  localparam logic [11:0] MAX_PAYLOAD_RST = 12'd4086;

  localparam logic [3:0] CFG_HANDLE_ENABLE = 4'd0;
  localparam logic [3:0] CFG_APP_ID_LO     = 4'd1;
  localparam logic [3:0] CFG_APP_ID_HI     = 4'd2;
  localparam logic [3:0] CFG_MSG_MIN_LO    = 4'd3;
  localparam logic [3:0] CFG_MSG_MIN_HI    = 4'd4;
  localparam logic [3:0] CFG_MSG_MAX_LO    = 4'd5;
  localparam logic [3:0] CFG_MSG_MAX_HI    = 4'd6;
  localparam logic [3:0] CFG_MAX_PAYLOAD   = 4'd7;

endpackage

// ----- rtl/ufdf_fifo.sv -----
module ufdf_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/ufdf_front.sv -----
module ufdf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  ufdf_pkg::in_item_t   in_data,
  output logic                 in_full,
  input  logic                 pop,
  output ufdf_pkg::cls_item_t  head,
  output logic                 empty
);

  ufdf_pkg::cls_item_t cls;

  // pre-decode the tick command and sync bytes so the parser sees flags
  always_comb begin
    cls.is_tick  = (in_data.command == ufdf_pkg::CMD_TICK);
    cls.is_sync1 = (in_data.rx_byte == ufdf_pkg::SYNC_FIRST);
    cls.is_sync2 = (in_data.rx_byte == ufdf_pkg::SYNC_SECOND);
    cls.rx_byte  = in_data.rx_byte;
  end

  ufdf_fifo #(
    .WIDTH($bits(ufdf_pkg::cls_item_t))
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls),
    .full  (in_full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

endmodule

// ----- rtl/ufdf_filter.sv -----
module ufdf_filter #(
  parameter int unsigned NUM_HANDLES = 15
) (
  input  ufdf_pkg::cfg_t              cfg,
  input  logic [7:0]                  app_id,
  input  logic [7:0]                  msg_id,
  output logic [ufdf_pkg::MASK_W-1:0] mask
);

  always_comb begin
    for (int h = 0; h < ufdf_pkg::MASK_W; h++) begin
      mask[h] = (h < NUM_HANDLES) && cfg.handle_enable[h] &&
                (cfg.app_id[8*h +: 8] == app_id) &&
                (msg_id >= cfg.msg_min[8*h +: 8]) &&
                (msg_id <= cfg.msg_max[8*h +: 8]);
    end
  end

endmodule

// ----- rtl/ufdf_back.sv -----
module ufdf_back #(
  parameter int unsigned NUM_HANDLES        = 15,
  parameter int unsigned FRAME_BUFFER_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ufdf_pkg::cfg_t       cfg,
  input  ufdf_pkg::cls_item_t  item,
  input  logic                 fire,
  output ufdf_pkg::out_item_t  result
);

  localparam logic [11:0] LEN_CAP = 12'(FRAME_BUFFER_BYTES
                                        - int'(ufdf_pkg::HEADER_BYTES)
                                        - int'(ufdf_pkg::CRC_BYTES));

  logic [12:0] byte_count_r, byte_count_nxt;
  logic [11:0] payload_length_r, payload_length_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [7:0]  app_id_r, app_id_nxt;
  logic [7:0]  msg_id_r, msg_id_nxt;
  logic        idle_r, idle_nxt;
  logic        byte_since_tick_r, byte_since_tick_nxt;

  logic [ufdf_pkg::MASK_W-1:0] mask;
  logic [11:0] limit;
  logic [15:0] len;
  logic [12:0] cnt_inc;
  logic [12:0] frame_end;

  ufdf_filter #(
    .NUM_HANDLES(NUM_HANDLES)
  ) u_filter (
    .cfg    (cfg),
    .app_id (app_id_r),
    .msg_id (msg_id_r),
    .mask   (mask)
  );

  always_comb begin
    byte_count_nxt      = byte_count_r;
    payload_length_nxt  = payload_length_r;
    length_high_nxt     = length_high_r;
    app_id_nxt          = app_id_r;
    msg_id_nxt          = msg_id_r;
    idle_nxt            = idle_r;
    byte_since_tick_nxt = byte_since_tick_r;

    result = '0;
    result.event_res = ufdf_pkg::EV_NONE;

    limit     = (cfg.max_payload < LEN_CAP) ? cfg.max_payload : LEN_CAP;
    len       = {length_high_r, item.rx_byte};
    cnt_inc   = byte_count_r + 13'd1;
    frame_end = {1'b0, payload_length_r} + ufdf_pkg::HEADER_BYTES + ufdf_pkg::CRC_BYTES;

    if (item.is_tick) begin
      if (byte_since_tick_r) begin
        idle_nxt            = 1'b0;
        byte_since_tick_nxt = 1'b0;
      end else if (byte_count_r != 13'd0) begin
        if (idle_r) begin
          // second idle tick in a row
          byte_count_nxt     = '0;
          payload_length_nxt = '0;
          idle_nxt           = 1'b0;
          result.event_res   = ufdf_pkg::EV_DROP;
        end else begin
          idle_nxt = 1'b1;
        end
      end
    end else begin
      byte_since_tick_nxt = 1'b1;
      if (byte_count_r == 13'd0) begin
        if (item.is_sync1) begin
          byte_count_nxt   = 13'd1;
          result.event_res = ufdf_pkg::EV_HELD;
          result.data_byte = item.rx_byte;
        end
      end else if (byte_count_r == ufdf_pkg::POS_SYNC2) begin
        result.data_byte = item.rx_byte;
        if (item.is_sync2) begin
          byte_count_nxt   = 13'd2;
          result.event_res = ufdf_pkg::EV_HELD;
          result.offset    = 12'd1;
        end else if (item.is_sync1) begin
          byte_count_nxt   = 13'd1;
          result.event_res = ufdf_pkg::EV_HELD;
        end else begin
          byte_count_nxt     = '0;
          payload_length_nxt = '0;
          result.event_res   = ufdf_pkg::EV_DROP;
        end
      end else if (byte_count_r == ufdf_pkg::POS_LEN_LO) begin
        result.data_byte = item.rx_byte;
        if (len > {4'd0, limit}) begin
          byte_count_nxt     = '0;
          payload_length_nxt = '0;
          result.event_res   = ufdf_pkg::EV_DROP;
        end else begin
          payload_length_nxt = len[11:0];
          byte_count_nxt     = cnt_inc;
          result.event_res   = ufdf_pkg::EV_HELD;
          result.offset      = byte_count_r[11:0];
        end
      end else begin
        if (byte_count_r == ufdf_pkg::POS_APP_ID) begin
          app_id_nxt = item.rx_byte;
        end else if (byte_count_r == ufdf_pkg::POS_MSG_ID) begin
          msg_id_nxt = item.rx_byte;
        end else if (byte_count_r == ufdf_pkg::POS_LEN_HI) begin
          length_high_nxt = item.rx_byte;
        end
        byte_count_nxt   = cnt_inc;
        result.data_byte = item.rx_byte;
        result.offset    = byte_count_r[11:0];
        if (byte_count_r >= ufdf_pkg::HEADER_BYTES && cnt_inc >= frame_end) begin
          result.event_res    = ufdf_pkg::EV_COMPLETE;
          result.match_mask   = mask;
          result.frame_length = cnt_inc;
          byte_count_nxt      = '0;
          payload_length_nxt  = '0;
        end else begin
          result.event_res = ufdf_pkg::EV_HELD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      payload_length_r  <= '0;
      length_high_r     <= '0;
      app_id_r          <= '0;
      msg_id_r          <= '0;
      idle_r            <= 1'b0;
      byte_since_tick_r <= 1'b0;
    end else if (fire) begin
      byte_count_r      <= byte_count_nxt;
      payload_length_r  <= payload_length_nxt;
      length_high_r     <= length_high_nxt;
      app_id_r          <= app_id_nxt;
      msg_id_r          <= msg_id_nxt;
      idle_r            <= idle_nxt;
      byte_since_tick_r <= byte_since_tick_nxt;
    end
  end

endmodule

// ----- rtl/uart_frame_deframer_filter.sv -----
// A result is registered in the input queue and then in the result queue before it is on out_data.
// Throughput: one item per cycle; the parser handles one queued item each cycle
// that the 2-entry result queue has room.
// Reset (rst_n low, synchronous): both queues empty, parser state zero,
// registers at reset values (max_payload 4086, all others zero).
module uart_frame_deframer_filter #(
  parameter int unsigned NUM_HANDLES        = 15,
  parameter int unsigned FRAME_BUFFER_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  ufdf_pkg::in_item_t   in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ufdf_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  ufdf_pkg::cfg_t      cfg_r, cfg_nxt;
  ufdf_pkg::cls_item_t head;
  ufdf_pkg::out_item_t result;
  logic                front_empty;
  logic                out_full;
  logic                fire;

  assign cfg_ready = 1'b1;
  assign fire      = !front_empty && !out_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ufdf_pkg::CFG_HANDLE_ENABLE: cfg_nxt.handle_enable   = cfg_data[14:0];
        ufdf_pkg::CFG_APP_ID_LO:     cfg_nxt.app_id[63:0]    = cfg_data;
        ufdf_pkg::CFG_APP_ID_HI:     cfg_nxt.app_id[119:64]  = cfg_data[55:0];
        ufdf_pkg::CFG_MSG_MIN_LO:    cfg_nxt.msg_min[63:0]   = cfg_data;
        ufdf_pkg::CFG_MSG_MIN_HI:    cfg_nxt.msg_min[119:64] = cfg_data[55:0];
        ufdf_pkg::CFG_MSG_MAX_LO:    cfg_nxt.msg_max[63:0]   = cfg_data;
        ufdf_pkg::CFG_MSG_MAX_HI:    cfg_nxt.msg_max[119:64] = cfg_data[55:0];
        ufdf_pkg::CFG_MAX_PAYLOAD:   cfg_nxt.max_payload     = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_payload: ufdf_pkg::MAX_PAYLOAD_RST, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ufdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .pop     (fire),
    .head    (head),
    .empty   (front_empty)
  );

  ufdf_back #(
    .NUM_HANDLES        (NUM_HANDLES),
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (head),
    .fire   (fire),
    .result (result)
  );

  ufdf_fifo #(
    .WIDTH($bits(ufdf_pkg::out_item_t))
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .din   (result),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

// ----- rtl/ufdf_checker.sv -----
`include "assert_macros.svh"

module ufdf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input ufdf_pkg::out_item_t out_data
);

  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> out_empty && !in_full, "queues not empty after reset")

  `ASSERT_RUN(a_out_hold, clk, rst_n, !out_empty && !out_pop |=> !out_empty && $stable(out_data), "stalled result beat changed")

  `ASSERT_RUN(a_len_on_complete, clk, rst_n, !out_empty |-> ((out_data.event_res == ufdf_pkg::EV_COMPLETE) == (out_data.frame_length != 13'd0)), "frame_length does not track completion")

  `ASSERT_RUN(a_mask_on_complete, clk, rst_n, !out_empty && out_data.event_res != ufdf_pkg::EV_COMPLETE |-> out_data.match_mask == '0, "match_mask set outside completion")

endmodule

bind uart_frame_deframer_filter ufdf_checker u_checker (.*);
